FILE: hdl/msh_pkg.sv
// Package with shared types and constants for the MinHash signature engine.
`default_nettype none

package msh_pkg;

   // Field widths of the request and response transactions.
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 6;
   localparam int SEED_W  = 31;
   localparam int HASH_W  = 32;
   localparam int SLOT_W  = 6;

   // djb2 start value and shift, and the value of an untouched minimum.
   localparam logic [HASH_W-1:0] HASH_START = 32'd5381;
   localparam int                HASH_SHIFT = 5;
   localparam logic [HASH_W-1:0] MIN_INIT   = 32'h7FFF_FFFF;

   // Depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = 2;

   // Request command codes.
   typedef enum logic [1:0] {
      CMD_LOAD_SEED     = 2'd0,
      CMD_SHINGLE_BYTE  = 2'd1,
      CMD_CLOSE_SHINGLE = 2'd2,
      CMD_CLOSE_DOC     = 2'd3
   } command_type;

   // Jobs handed from the front to the back.
   typedef enum logic [1:0] {
      OP_SEED    = 2'd0,
      OP_SHINGLE = 2'd1,
      OP_DOC     = 2'd2
   } op_type;

   // One queued job: seed write, shingle close with its hash, or document close.
   typedef struct packed {
      op_type              op;
      logic [INDEX_W-1:0]  index;
      logic [HASH_W-1:0]   word;
   } job_type;

   // Push side of the job queue.
   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

endpackage

`default_nettype wire

FILE: hdl/msh_if.sv
// Handshake interfaces for the request and response channels.
`default_nettype none

interface msh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  data_byte;
   logic [5:0]  seed_index;
   logic [30:0] seed_value;

   modport source (output valid, command, data_byte, seed_index, seed_value, input ready);
   modport sink   (input valid, command, data_byte, seed_index, seed_value, output ready);
endinterface

interface msh_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         slot;
   logic signed [31:0] min_value;
   logic               empty_document;
   logic               last;

   modport source (output valid, slot, min_value, empty_document, last, input ready);
   modport sink   (input valid, slot, min_value, empty_document, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/minhash_signature_engine_unit.sv
// Top level of the MinHash signature engine: front end, job queue and back end.
// Throughput: one command per cycle while the job queue has room; a close-document
// transaction holds the back end for all NUM_HASHES slots, one signature slot per cycle
// through the output register while it is free. Every job waits in the job queue;
// seed and shingle jobs pop as they run, a document job pops with its final slot.
// Reset (synchronous, active high): seeds zero, minima 0x7FFFFFFF, hash 5381, queue empty.
`default_nettype none

module minhash_signature_engine_unit #(
   parameter int NUM_HASHES = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   msh_req_if.sink   req_bus,
   msh_rsp_if.source rsp_bus
);
   import msh_pkg::*;

   push_type push;
   logic     push_ready;
   job_type  head_job;
   logic     head_valid;
   logic     pop_ready;

   msh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push       (push),
      .push_ready (push_ready)
   );

   msh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head_job   (head_job),
      .head_valid (head_valid),
      .pop_ready  (pop_ready)
   );

   msh_back #(
      .NUM_HASHES (NUM_HASHES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_valid (head_valid),
      .pop_ready  (pop_ready),
      .rsp        (rsp_bus)
   );

   // The back end never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop_ready |-> head_valid)
      else $error("back end popped an empty job queue");

   // The queue is empty and ready right after reset.
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> req_bus.ready)
      else $error("request side not ready after reset");

   // The last mark sits on the final slot only.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.last == (rsp_bus.slot == SLOT_W'(NUM_HASHES - 1))))
      else $error("last mark does not match the final slot");

endmodule

`default_nettype wire

FILE: hdl/msh_front.sv
// Front end: accepts commands, folds shingle bytes into the djb2 hash, queues jobs.
`default_nettype none

module msh_front (
   input  wire logic              clock,
   input  wire logic              reset,
   msh_req_if.sink                req,
   output msh_pkg::push_type      push,
   input  wire logic              push_ready
);
   import msh_pkg::*;

   logic [HASH_W-1:0] hash_ff;
   logic [HASH_W-1:0] hash_in;
   command_type       cmd;
   logic              accept;

   assign cmd       = command_type'(req.command);
   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   // Decode the command into a queued job and the next running hash.
   always_comb begin
      hash_in = hash_ff;
      push    = '0;
      case (cmd)
         CMD_LOAD_SEED: begin
            push.valid     = req.valid;
            push.job.op    = OP_SEED;
            push.job.index = req.seed_index;
            push.job.word  = {1'b0, req.seed_value};
         end
         CMD_SHINGLE_BYTE: begin
            if (accept) begin
               hash_in = (hash_ff << HASH_SHIFT) + hash_ff + HASH_W'(req.data_byte);
            end
         end
         CMD_CLOSE_SHINGLE: begin
            push.valid    = req.valid;
            push.job.op   = OP_SHINGLE;
            push.job.word = hash_ff;
            if (accept) begin
               hash_in = HASH_START;
            end
         end
         CMD_CLOSE_DOC: begin
            push.valid  = req.valid;
            push.job.op = OP_DOC;
            if (accept) begin
               hash_in = HASH_START;
            end
         end
         default: begin
            hash_in = hash_ff;
         end
      endcase
   end

   // Running hash register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= HASH_START;
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/msh_queue.sv
// Short job queue that decouples the command front end from the minima back end.
`default_nettype none

module msh_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire msh_pkg::push_type push,
   output logic                   push_ready,
   output msh_pkg::job_type       head_job,
   output logic                   head_valid,
   input  wire logic              pop_ready
);
   import msh_pkg::*;

   localparam logic [PTR_W:0] COUNT_FULL = (PTR_W+1)'(QUEUE_DEPTH);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [PTR_W:0]   count_ff;
   logic [PTR_W:0]   count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != COUNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop_ready && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset; the fill count guards it.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/msh_back.sv
// Back end: holds seeds and minima, updates all minima on a shingle close, emits signatures.
`default_nettype none

module msh_back #(
   parameter int NUM_HASHES = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire msh_pkg::job_type head_job,
   input  wire logic             head_valid,
   output logic                  pop_ready,
   msh_rsp_if.source             rsp
);
   import msh_pkg::*;

   localparam int              CNT_W    = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_HASHES - 1);
   localparam logic [INDEX_W:0] NUM_SLOTS = (INDEX_W+1)'(NUM_HASHES);

   logic [SEED_W-1:0] seed_ff [NUM_HASHES];
   logic [SEED_W-1:0] seed_in [NUM_HASHES];
   logic [HASH_W-1:0] min_ff  [NUM_HASHES];
   logic [HASH_W-1:0] min_in  [NUM_HASHES];
   logic              seen_ff;
   logic              seen_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;
   logic [HASH_W-1:0] value_ff;
   logic [HASH_W-1:0] value_in;
   logic              empty_ff;
   logic              empty_in;
   logic              last_ff;
   logic              last_in;
   logic              load_out;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp.ready;

   // Carry out the job at the queue head.
   always_comb begin
      logic [HASH_W-1:0] xor_val;
      seed_in      = seed_ff;
      min_in       = min_ff;
      seen_in      = seen_ff;
      cnt_in       = cnt_ff;
      pop_ready    = 1'b0;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      slot_in      = slot_ff;
      value_in     = value_ff;
      empty_in     = empty_ff;
      last_in      = last_ff;
      xor_val      = '0;
      if (head_valid) begin
         case (head_job.op)
            OP_SEED: begin
               pop_ready = 1'b1;
               if ({1'b0, head_job.index} < NUM_SLOTS) begin
                  seed_in[head_job.index[CNT_W-1:0]] = head_job.word[SEED_W-1:0];
               end
            end
            OP_SHINGLE: begin
               // One signed comparator per seed slot.
               pop_ready = 1'b1;
               seen_in   = 1'b1;
               for (int i = 0; i < NUM_HASHES; i++) begin
                  xor_val = head_job.word ^ {1'b0, seed_ff[i]};
                  if ($signed(xor_val) < $signed(min_ff[i])) begin
                     min_in[i] = xor_val;
                  end
               end
            end
            OP_DOC: begin
               // Give out one slot per cycle while the output register is free; clear the minima with the final one.
               if (out_free) begin
                  load_out     = 1'b1;
                  rsp_valid_in = 1'b1;
                  slot_in      = SLOT_W'(cnt_ff);
                  value_in     = seen_ff ? min_ff[cnt_ff] : MIN_INIT;
                  empty_in     = !seen_ff;
                  last_in      = (cnt_ff == LAST_CNT);
                  if (cnt_ff == LAST_CNT) begin
                     pop_ready = 1'b1;
                     cnt_in    = '0;
                     seen_in   = 1'b0;
                     for (int i = 0; i < NUM_HASHES; i++) begin
                        min_in[i] = MIN_INIT;
                     end
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
            end
            default: begin
               pop_ready = 1'b1;
            end
         endcase
      end
   end

   // Architectural state and control.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_HASHES; i++) begin
            seed_ff[i] <= '0;
            min_ff[i]  <= MIN_INIT;
         end
         seen_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         min_ff       <= min_in;
         seen_ff      <= seen_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load_out) begin
         slot_ff  <= slot_in;
         value_ff <= value_in;
         empty_ff <= empty_in;
         last_ff  <= last_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.slot           = slot_ff;
   assign rsp.min_value      = value_ff;
   assign rsp.empty_document = empty_ff;
   assign rsp.last           = last_ff;

endmodule

`default_nettype wire

FILE: test/minhash_signature_checker.sv
// Checker that watches both channels, predicts each signature and compares the results.
`default_nettype none

module minhash_signature_checker
   import msh_pkg::*;
#(
   parameter int NUM_HASHES = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   msh_req_if        req_mon,
   msh_rsp_if        rsp_mon,
   output int        error_count,
   output int        pending_count,
   output int        checked_count,
   output int        document_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // One expected signature slot.
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [HASH_W-1:0] min_value;
      logic              empty_document;
      logic              last;
   } signature_slot_type;

   signature_slot_type expected_slots[$];

   // Private copy of the engine state.
   logic [SEED_W-1:0] seed_words[NUM_HASHES];
   logic [HASH_W-1:0] shingle_hash;
   logic [HASH_W-1:0] slot_minima[NUM_HASHES];
   logic              shingle_closed;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Minima back to their start values at the end of every document.
   task automatic clear_signature();
      for (int i = 0; i < NUM_HASHES; i++) begin
         slot_minima[i] = MIN_INIT;
      end
      shingle_closed = 1'b0;
   endtask

   // Advance the state by one accepted request and queue any signature it releases.
   task automatic predict_command();
      logic [HASH_W-1:0]  mixed;
      signature_slot_type entry;
      case (command_type'(req_mon.command))
         CMD_LOAD_SEED: begin
            // Slots past the table are dropped.
            if (req_mon.seed_index < NUM_HASHES) begin
               seed_words[req_mon.seed_index] = req_mon.seed_value;
            end
         end
         CMD_SHINGLE_BYTE: begin
            shingle_hash = HASH_W'((shingle_hash << 5) + shingle_hash
                                   + HASH_W'(req_mon.data_byte));
         end
         CMD_CLOSE_SHINGLE: begin
            for (int i = 0; i < NUM_HASHES; i++) begin
               mixed = shingle_hash ^ {1'b0, seed_words[i]};
               if ($signed(mixed) < $signed(slot_minima[i])) begin
                  slot_minima[i] = mixed;
               end
            end
            shingle_closed = 1'b1;
            shingle_hash   = HASH_START;
         end
         CMD_CLOSE_DOC: begin
            for (int i = 0; i < NUM_HASHES; i++) begin
               entry.slot           = SLOT_W'(i);
               entry.min_value      = shingle_closed ? slot_minima[i] : MIN_INIT;
               entry.empty_document = !shingle_closed;
               entry.last           = (i == NUM_HASHES - 1);
               expected_slots.push_back(entry);
            end
            document_count++;
            clear_signature();
            // Bytes of a shingle left open are dropped.
            shingle_hash = HASH_START;
         end
         default: begin
            report_mismatch("unknown command accepted");
         end
      endcase
   endtask

   // Compare one accepted response transaction with the oldest expected slot.
   task automatic compare_slot();
      signature_slot_type entry;
      if (expected_slots.size() == 0) begin
         report_mismatch($sformatf("unexpected slot %0d value %0d",
                                   rsp_mon.slot, rsp_mon.min_value));
      end else begin
         entry = expected_slots.pop_front();
         checked_count++;
         if (rsp_mon.slot !== entry.slot) begin
            report_mismatch($sformatf("slot %0d, expected %0d", rsp_mon.slot, entry.slot));
         end
         if (rsp_mon.min_value !== entry.min_value) begin
            report_mismatch($sformatf("slot %0d min_value %0d, expected %0d", entry.slot,
                                      rsp_mon.min_value, $signed(entry.min_value)));
         end
         if (rsp_mon.empty_document !== entry.empty_document) begin
            report_mismatch($sformatf("slot %0d empty_document %b, expected %b", entry.slot,
                                      rsp_mon.empty_document, entry.empty_document));
         end
         if (rsp_mon.last !== entry.last) begin
            report_mismatch($sformatf("slot %0d last %b, expected %b", entry.slot,
                                      rsp_mon.last, entry.last));
         end
      end
   endtask

   // Sample both channels at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_HASHES; i++) begin
            seed_words[i] = '0;
         end
         shingle_hash = HASH_START;
         clear_signature();
         expected_slots.delete();
         error_count    = 0;
         checked_count  = 0;
         document_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predict_command();
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            compare_slot();
         end
      end
      pending_count = expected_slots.size();
   end

endmodule

`default_nettype wire

FILE: test/minhash_signature_engine_unit_tb.sv
// Testbench top: drives commands and response stalls, and gives the verdict.
`default_nettype none

module minhash_signature_engine_unit_tb;
   import msh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_HASHES  = 8;
   localparam int ITEM_TARGET = 320;
   localparam int CALM_ITEMS  = 40;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   items_sent  = 0;
   logic sender_idles_on = 1'b1;
   logic rsp_stalls_on   = 1'b1;
   int   rsp_hold        = 0;
   int   error_count;
   int   pending_count;
   int   checked_count;
   int   document_count;

   msh_req_if req_bus();
   msh_rsp_if rsp_bus();

   minhash_signature_engine_unit #(
      .NUM_HASHES(NUM_HASHES)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   minhash_signature_checker #(
      .NUM_HASHES(NUM_HASHES)
   ) signature_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .document_count (document_count)
   );

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard stop if the engine hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d slots outstanding.",
                  cycle_count, pending_count);
         $display("[minhash_signature_engine_unit] ERROR");
         $finish;
      end
   end

   // Response ready, dropped at random in stall bursts.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= rsp_hold - 1;
      end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= $urandom_range(0, 15);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Present one request transaction and hold it until it is taken.
   task automatic send_command(input command_type cmd, input logic [BYTE_W-1:0] data,
                               input logic [INDEX_W-1:0] index,
                               input logic [SEED_W-1:0] seed);
      req_bus.valid      = 1'b1;
      req_bus.command    = cmd;
      req_bus.data_byte  = data;
      req_bus.seed_index = index;
      req_bus.seed_value = seed;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Don't-care fields are filled with random values.
   task automatic send_byte(input logic [BYTE_W-1:0] data);
      send_command(CMD_SHINGLE_BYTE, data, INDEX_W'($urandom), SEED_W'($urandom));
   endtask

   task automatic send_seed(input logic [INDEX_W-1:0] index, input logic [SEED_W-1:0] seed);
      send_command(CMD_LOAD_SEED, BYTE_W'($urandom), index, seed);
   endtask

   task automatic send_close(input command_type cmd);
      send_command(cmd, BYTE_W'($urandom), INDEX_W'($urandom), SEED_W'($urandom));
   endtask

   // Drop valid for a number of cycles, with junk on the payload.
   task automatic pause_sender(input int cycles);
      req_bus.valid      = 1'b0;
      req_bus.command    = command_type'(2'($urandom));
      req_bus.data_byte  = BYTE_W'($urandom);
      req_bus.seed_index = INDEX_W'($urandom);
      req_bus.seed_value = SEED_W'($urandom);
      repeat (cycles) @(negedge clock);
   endtask

   task automatic maybe_pause();
      if (sender_idles_on && $urandom_range(0, 4) == 0) begin
         pause_sender($urandom_range(1, 16));
      end
   endtask

   // Hold the sender off until every expected slot has come out.
   task automatic drain_signatures();
      req_bus.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // A random document: well-formed shingles, sometimes one left open at the end.
   task automatic send_document();
      int shingles;
      int length;
      shingles = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
      for (int s = 0; s < shingles; s++) begin
         length = $urandom_range(0, 6);
         for (int b = 0; b < length; b++) begin
            maybe_pause();
            send_byte(BYTE_W'($urandom));
         end
         maybe_pause();
         send_close(CMD_CLOSE_SHINGLE);
      end
      if ($urandom_range(0, 4) == 0) begin
         length = $urandom_range(1, 4);
         for (int b = 0; b < length; b++) begin
            maybe_pause();
            send_byte(BYTE_W'($urandom));
         end
      end
      maybe_pause();
      send_close(CMD_CLOSE_DOC);
   endtask

   // Stimulus: directed cases, then random documents, seed loads and noise.
   initial begin
      logic mid_drain_done;
      mid_drain_done     = 1'b0;
      reset              = 1'b1;
      rsp_bus.ready      = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_LOAD_SEED;
      req_bus.data_byte  = '0;
      req_bus.seed_index = '0;
      req_bus.seed_value = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty document straight out of reset.
      send_close(CMD_CLOSE_DOC);
      // Seed extremes, plus two slots past the table that must be ignored.
      send_seed(6'd0, 31'h7FFF_FFFF);
      send_seed(INDEX_W'(NUM_HASHES - 1), 31'h0);
      send_seed(6'd3, 31'h2AAA_AAAA);
      send_seed(6'd63, 31'h1234_5678);
      send_seed(INDEX_W'(NUM_HASHES), 31'h7FFF_FFFF);
      // Shingle with no bytes, then zero and all-ones bytes.
      send_close(CMD_CLOSE_SHINGLE);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_close(CMD_CLOSE_SHINGLE);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_close(CMD_CLOSE_SHINGLE);
      // Open shingle dropped by the document close, then another empty document.
      send_byte(8'hAA);
      send_close(CMD_CLOSE_DOC);
      send_close(CMD_CLOSE_DOC);
      // Long shingle so the hash wraps.
      repeat (6) send_byte(8'hFF);
      send_close(CMD_CLOSE_SHINGLE);
      send_close(CMD_CLOSE_DOC);
      drain_signatures();

      // Random part; the final stretch runs with no idling on either side.
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - CALM_ITEMS) begin
            sender_idles_on = 1'b0;
            rsp_stalls_on   = 1'b0;
         end else begin
            sender_idles_on = ($urandom_range(0, 3) != 0);
            rsp_stalls_on   = ($urandom_range(0, 3) != 0);
         end
         if (!mid_drain_done && items_sent >= ITEM_TARGET / 2) begin
            drain_signatures();
            mid_drain_done = 1'b1;
         end
         case ($urandom_range(0, 9))
            0: begin
               maybe_pause();
               send_command(command_type'(2'($urandom)), BYTE_W'($urandom),
                            INDEX_W'($urandom), SEED_W'($urandom));
            end
            1: begin
               repeat ($urandom_range(1, 4)) begin
                  maybe_pause();
                  if ($urandom_range(0, 5) == 0) begin
                     send_seed(INDEX_W'($urandom), SEED_W'($urandom));
                  end else begin
                     send_seed(INDEX_W'($urandom_range(0, NUM_HASHES - 1)),
                               SEED_W'($urandom));
                  end
               end
            end
            default: send_document();
         endcase
      end

      // Let the last signatures out, then allow for the pipeline.
      req_bus.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (NUM_HASHES + 8) @(negedge clock);

      $display("Sent %0d request transactions covering %0d documents.",
               items_sent, document_count);
      $display("Checked %0d signature slots; %0d mismatches.", checked_count, error_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("[minhash_signature_engine_unit] OK");
      end else begin
         $display("[minhash_signature_engine_unit] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
hdl/msh_pkg.sv
hdl/msh_if.sv
hdl/msh_front.sv
hdl/msh_queue.sv
hdl/msh_back.sv
hdl/minhash_signature_engine_unit.sv
test/minhash_signature_checker.sv
test/minhash_signature_engine_unit_tb.sv
